/* sv/btr_pkg.sv */
// Package for the branch target resolver: form codes, condition codes,
// pipeline stage payload types and the condition evaluation function.
// No dependencies.
`default_nettype none

package btr_pkg;

    // Decoded instruction form, as reported on the result channel
    typedef enum logic [1:0] {
        FORM_B     = 2'd0,
        FORM_BR    = 2'd1,
        FORM_BCOND = 2'd2
    } form_t;

    // Encoding patterns
    localparam logic [21:0] BR_TOP_PATTERN = 22'h3587C0;
    localparam logic [7:0]  BCOND_TOP      = 8'h54;
    localparam logic [63:0] INSN_BYTES     = 64'd4;

    // Supported condition codes
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_GE = 4'hA;
    localparam logic [3:0] COND_LT = 4'hB;
    localparam logic [3:0] COND_GT = 4'hC;
    localparam logic [3:0] COND_LE = 4'hD;
    localparam logic [3:0] COND_AL = 4'hE;

    // Decode stage result
    typedef struct packed {
        logic [63:0] pc;
        logic [63:0] addend;
        logic [63:0] reg_value;
        logic        taken;
        form_t       form;
    } dec_t;

    // Low-half add stage result
    typedef struct packed {
        logic [31:0] sum_lo;
        logic        carry;
        logic [31:0] pc_hi;
        logic [31:0] addend_hi;
        logic [63:0] reg_value;
        logic        taken;
        form_t       form;
    } add_lo_t;

    // Condition check on N, Z, V; unsupported codes are never taken
    function automatic logic cond_holds(input logic [3:0] cond, input logic n,
                                        input logic z, input logic v);
        logic res;
        case (cond)
            COND_EQ: res = z;
            COND_NE: res = !z;
            COND_GE: res = (n == v);
            COND_LT: res = (n != v);
            COND_GT: res = !z && (n == v);
            COND_LE: res = z || (n != v);
            COND_AL: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

/* sv/btr_decode.sv */
// Decode stage: recognizes BR / B.cond / B, evaluates the condition and
// selects the addend for the target add. Depends on btr_pkg.
`default_nettype none

module btr_decode (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [31:0]   instruction,
    input  wire logic [63:0]   pc,
    input  wire logic [63:0]   reg_value,
    input  wire logic          flag_n,
    input  wire logic          flag_z,
    input  wire logic          flag_v,
    output logic               out_valid,
    input  wire logic          out_ready,
    output btr_pkg::dec_t      out_data
);

    logic          valid_reg;
    logic          valid_next;
    btr_pkg::dec_t data_reg;
    btr_pkg::dec_t data_next;
    logic          is_br;
    logic          is_bcond;
    logic          cond_ok;
    logic [63:0]   off19;
    logic [63:0]   off26;

    // Stage accepts when empty or when its content moves on
    assign in_ready = !valid_reg || out_ready;

    // Field decode
    always_comb begin
        is_br    = (instruction[4:0] == 5'd0) &&
                   (instruction[31:10] == btr_pkg::BR_TOP_PATTERN);
        is_bcond = !instruction[4] && (instruction[31:24] == btr_pkg::BCOND_TOP);
        cond_ok  = btr_pkg::cond_holds(instruction[3:0], flag_n, flag_z, flag_v);
        off19    = {{43{instruction[23]}}, instruction[23:5], 2'b00};
        off26    = {{36{instruction[25]}}, instruction[25:0], 2'b00};
    end

    // Stage payload
    always_comb begin
        data_next.pc        = pc;
        data_next.reg_value = reg_value;
        if (is_br) begin
            data_next.addend = btr_pkg::INSN_BYTES;
            data_next.taken  = 1'b1;
            data_next.form   = btr_pkg::FORM_BR;
        end else if (is_bcond) begin
            data_next.addend = cond_ok ? off19 : btr_pkg::INSN_BYTES;
            data_next.taken  = cond_ok;
            data_next.form   = btr_pkg::FORM_BCOND;
        end else begin
            data_next.addend = off26;
            data_next.taken  = 1'b1;
            data_next.form   = btr_pkg::FORM_B;
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* sv/btr_adder.sv */
// Split 64-bit target adder: low half with carry in one stage, high half
// and final selection in the next (output register). Depends on btr_pkg.
`default_nettype none

module btr_adder (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire btr_pkg::dec_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [63:0]          next_pc,
    output logic                 taken,
    output logic [1:0]           form
);

    logic             lo_valid_reg;
    logic             lo_valid_next;
    logic             lo_ready;
    btr_pkg::add_lo_t lo_reg;
    btr_pkg::add_lo_t lo_next;
    logic             hi_valid_reg;
    logic             hi_valid_next;
    logic [32:0]      lo_sum;
    logic [31:0]      hi_sum;
    logic [63:0]      pc_next;
    logic [63:0]      pc_reg;
    logic             taken_reg;
    btr_pkg::form_t   form_reg;

    // Per-stage ready: a stage takes a transfer when empty or draining
    assign in_ready = !lo_valid_reg || lo_ready;
    assign lo_ready = !hi_valid_reg || out_ready;

    // Low half add, carry kept for the next stage
    always_comb begin
        lo_sum            = {1'b0, in_data.pc[31:0]} + {1'b0, in_data.addend[31:0]};
        lo_next.sum_lo    = lo_sum[31:0];
        lo_next.carry     = lo_sum[32];
        lo_next.pc_hi     = in_data.pc[63:32];
        lo_next.addend_hi = in_data.addend[63:32];
        lo_next.reg_value = in_data.reg_value;
        lo_next.taken     = in_data.taken;
        lo_next.form      = in_data.form;
    end

    assign lo_valid_next = in_ready ? in_valid : lo_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_valid_reg <= 1'b0;
        end else begin
            lo_valid_reg <= lo_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            lo_reg <= lo_next;
        end
    end

    // High half add and target select; BR goes to the register exactly
    always_comb begin
        hi_sum = lo_reg.pc_hi + lo_reg.addend_hi + {31'd0, lo_reg.carry};
        if (lo_reg.form == btr_pkg::FORM_BR) begin
            pc_next = lo_reg.reg_value;
        end else begin
            pc_next = {hi_sum, lo_reg.sum_lo};
        end
    end

    assign hi_valid_next = lo_ready ? lo_valid_reg : hi_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_valid_reg <= 1'b0;
        end else begin
            hi_valid_reg <= hi_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (lo_ready && lo_valid_reg) begin
            pc_reg    <= pc_next;
            taken_reg <= lo_reg.taken;
            form_reg  <= lo_reg.form;
        end
    end

    assign out_valid = hi_valid_reg;
    assign next_pc   = pc_reg;
    assign taken     = taken_reg;
    assign form      = form_reg;

endmodule

`default_nettype wire

/* sv/branch_target_resolver_unit.sv */
// Top level of the branch target resolver: decode stage followed by the
// split target adder. Depends on btr_pkg, btr_decode, btr_adder.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  instruction, pc, reg_value, flags
//   m_        out        m_valid / m_ready  next_pc, taken, form
//
// Three register stages: decode, low 32-bit add, high 32-bit add with target
// select into the output register. An accepted item passes the decode, low-add
// and high-add registers in that order before m_valid rises for it.
// One item per cycle is sustained while m_ready stays high.
// Each stage has its own valid bit and stalls only when full and blocked,
// so bubbles close up and new items enter while a result waits.
// aresetn (synchronous, active low) clears the valid bits only.
`default_nettype none

module branch_target_resolver_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_instruction,
    input  wire logic [63:0] s_pc,
    input  wire logic [63:0] s_reg_value,
    input  wire logic        s_flag_n,
    input  wire logic        s_flag_z,
    input  wire logic        s_flag_v,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_next_pc,
    output logic             m_taken,
    output logic [1:0]       m_form
);

    logic          dec_valid;
    logic          dec_ready;
    btr_pkg::dec_t dec_data;

    // Stage 1: decode and condition
    btr_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .instruction (s_instruction),
        .pc          (s_pc),
        .reg_value   (s_reg_value),
        .flag_n      (s_flag_n),
        .flag_z      (s_flag_z),
        .flag_v      (s_flag_v),
        .out_valid   (dec_valid),
        .out_ready   (dec_ready),
        .out_data    (dec_data)
    );

    // Stages 2 and 3: target add and output register
    btr_adder u_adder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .next_pc   (m_next_pc),
        .taken     (m_taken),
        .form      (m_form)
    );

endmodule

`default_nettype wire

/* sv/btr_checker.sv */
// Port-level checks for branch_target_resolver_unit, bound to the top level.
// Depends on btr_pkg.
`default_nettype none

module btr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_next_pc,
    input wire logic        m_taken,
    input wire logic [1:0]  m_form
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_pc) && $stable(m_taken)
            && $stable(m_form))
        else $error("result changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // BR always reports taken
    a_br_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_form == btr_pkg::FORM_BR) |-> m_taken)
        else $error("BR reported not taken");

    // Only a conditional branch can fall through
    a_not_taken_bcond: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_taken |-> (m_form == btr_pkg::FORM_BCOND))
        else $error("not-taken result from an unconditional form");

endmodule

bind branch_target_resolver_unit btr_checker u_btr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_next_pc (m_next_pc),
    .m_taken   (m_taken),
    .m_form    (m_form)
);

`default_nettype wire
